FILE: hdl/motor_command_refresh_scheduler_macros.svh
// Assertion macros for the motor command refresh scheduler.
// Each check is compiled only when SYNTH is not defined.
`ifndef MOTOR_COMMAND_REFRESH_SCHEDULER_MACROS_SVH
`define MOTOR_COMMAND_REFRESH_SCHEDULER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MCRS_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mcrs check failed: same-cycle implication");
// next-cycle implication
`define MCRS_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mcrs check failed: next-cycle implication");
`else
`define MCRS_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define MCRS_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif

`endif

FILE: hdl/mcrs_pkg.sv
package mcrs_pkg;

    // slot count limits
    localparam int MOTOR_COUNT_DEF = 2;
    localparam int SLOT_MAX        = 2;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ID  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_ID = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [7:0]  FIRST_ID_RST  = 8'd1;
    localparam logic [7:0]  SECOND_ID_RST = 8'd2;
    localparam logic [15:0] TIMEOUT_RST   = 16'd10000;

    // input item kinds
    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_SPEED       = 3'd1,
        KIND_POSITION    = 3'd2,
        KIND_POS_SPD_ACC = 3'd3,
        KIND_CURRENT     = 3'd4,
        KIND_STOP        = 3'd5,
        KIND_STOP_ALL    = 3'd6,
        KIND_ORIGIN      = 3'd7
    } t_kind;

    // slot control modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SPEED   = 3'd1,
        MODE_POS     = 3'd2,
        MODE_PSA     = 3'd3,
        MODE_CURRENT = 3'd4
    } t_mode;

    // packet codes in the upper byte of the extended id
    localparam logic [7:0] PKT_CURRENT = 8'd1;
    localparam logic [7:0] PKT_RPM     = 8'd3;
    localparam logic [7:0] PKT_POS     = 8'd4;
    localparam logic [7:0] PKT_ORIGIN  = 8'd5;
    localparam logic [7:0] PKT_POS_SPD = 8'd6;

    localparam logic [3:0] BYTES_ORIGIN = 4'd1;
    localparam logic [3:0] BYTES_VALUE  = 4'd4;
    localparam logic [3:0] BYTES_PSA    = 4'd8;

    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic signed [15:0] CURRENT_LIMIT = 16'sd5000;

    // x / 10 for 16-bit unsigned x, exact over the whole range
    localparam logic [15:0] DIV10_MULT  = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // frame queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] frame_id;
        logic        tx_slot;
        logic [3:0]  byte_count;
        logic [31:0] payload_high;
        logic [31:0] payload_low;
        logic        last_frame;
    } t_frame;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               room_for_pair;
    } t_queue_status;

    function automatic t_frame make_frame(input logic [7:0] id, input logic [7:0] code,
                                          input logic [3:0] len, input logic [31:0] hi,
                                          input logic [31:0] lo);
        t_frame f;
        f.frame_id     = {code, id};
        f.tx_slot      = (id != 8'd1);
        f.byte_count   = len;
        f.payload_high = hi;
        f.payload_low  = lo;
        f.last_frame   = 1'b0;
        return f;
    endfunction

    // clamp to the current limit and sign-extend
    function automatic logic [31:0] clamp_current(input logic signed [15:0] ma);
        logic signed [15:0] v;
        v = ma;
        if (ma > CURRENT_LIMIT) v = CURRENT_LIMIT;
        if (ma < -CURRENT_LIMIT) v = -CURRENT_LIMIT;
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [15:0] div10_mag(input logic [15:0] mag);
        logic [31:0] prod;
        prod = 32'(mag) * 32'(DIV10_MULT);
        return 16'(prod >> DIV10_SHIFT);
    endfunction

    // truncate toward zero
    function automatic logic [15:0] speed_div10(input logic signed [15:0] v);
        logic [15:0] mag;
        logic [15:0] q;
        mag = v[15] ? (~v + 16'd1) : v;
        q   = div10_mag(mag);
        return v[15] ? (~q + 16'd1) : q;
    endfunction

    // negative acceleration sends zero
    function automatic logic [15:0] accel_div10(input logic signed [15:0] v);
        return v[15] ? 16'd0 : div10_mag(v);
    endfunction

endpackage

FILE: hdl/mcrs_if.sv
// Command word channel
interface mcrs_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         target_id;
    logic signed [31:0] position_e4;
    logic signed [15:0] speed_erpm;
    logic signed [15:0] accel_erpm;
    logic signed [15:0] current_ma;
    logic [7:0]         home_mode;

    modport source (output valid, kind, target_id, position_e4, speed_erpm, accel_erpm,
                    current_ma, home_mode, input ready);
    modport sink   (input valid, kind, target_id, position_e4, speed_erpm, accel_erpm,
                    current_ma, home_mode, output ready);
endinterface

// Bus frame channel
interface mcrs_frame_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_id;
    logic        tx_slot;
    logic [3:0]  byte_count;
    logic [31:0] payload_high;
    logic [31:0] payload_low;
    logic        last_frame;

    modport source (output valid, frame_id, tx_slot, byte_count, payload_high, payload_low,
                    last_frame, input ready);
    modport sink   (input valid, frame_id, tx_slot, byte_count, payload_high, payload_low,
                    last_frame, output ready);
endinterface

// Register write channel
interface mcrs_cfg_if;
    import mcrs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/mcrs_frame_queue.sv
module mcrs_frame_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_count,
    input  mcrs_pkg::t_frame      i_push0,
    input  mcrs_pkg::t_frame      i_push1,
    input  logic                  i_pop,
    output mcrs_pkg::t_frame      o_head,
    output mcrs_pkg::t_queue_status o_status
);
    import mcrs_pkg::*;

    t_frame               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr;
    logic [QUEUE_PTR_W-1:0] r_rd;
    logic [LEVEL_W-1:0]   r_level;

    // store up to two words per cycle
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr + QUEUE_PTR_W'(1)] <= i_push1;
        end
    end

    // advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + QUEUE_PTR_W'(i_push_count);
            r_rd    <= r_rd + QUEUE_PTR_W'(i_pop);
            r_level <= r_level + LEVEL_W'(i_push_count) - LEVEL_W'(i_pop);
        end
    end

    assign o_head                 = r_mem[r_rd];
    assign o_status.level         = r_level;
    assign o_status.room_for_pair = (r_level <= LEVEL_W'(QUEUE_DEPTH - 2));

endmodule

FILE: hdl/motor_command_refresh_scheduler.sv
// Motor command refresh scheduler.
// i_cmd carries command words (tick, speed, position, position-speed-accel,
// current, stop, stop-all, origin); o_frame carries bus frames, one word per
// frame, last_frame marking the final frame caused by a command word.
// i_cfg writes the two slot bus ids and the silence timeout; it is always ready.
// A frame caused by a word is written into the frame queue when the word is
// accepted, and is offered on o_frame once the frames ahead of it are taken.
// The slot state is updated on that edge, so the next word may follow at once.
// Throughput: one word per cycle while i_cmd.ready is high and the word causes
// at most one frame; words that cause two frames (tick with both slots active,
// stop-all, origin) wait on the single read port of the four-entry frame queue.
// Reset: ids 1 and 2, timeout 10000 ticks, both slots idle, queue empty.
// Stall: frames wait in the queue while o_frame.ready is low; i_cmd.ready drops
// when fewer than two queue entries are free, so no frame is ever lost.
`include "motor_command_refresh_scheduler_macros.svh"

module motor_command_refresh_scheduler #(
    parameter int MOTOR_COUNT = mcrs_pkg::MOTOR_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mcrs_cmd_if.sink  i_cmd,
    mcrs_cfg_if.sink  i_cfg,
    mcrs_frame_if.source o_frame
);
    import mcrs_pkg::*;

    localparam int SLOTS = (MOTOR_COUNT < SLOT_MAX) ? MOTOR_COUNT : SLOT_MAX;

    // configuration registers
    logic [7:0]  r_first_id;
    logic [7:0]  r_second_id;
    logic [15:0] r_timeout;

    // slot state
    t_mode               r_mode  [SLOTS];
    logic [31:0]         r_pos   [SLOTS];
    logic signed [15:0]  r_spd   [SLOTS];
    logic signed [15:0]  r_acc   [SLOTS];
    logic signed [15:0]  r_cur   [SLOTS];
    logic [COUNT_W-1:0]  r_count [SLOTS];

    t_mode               n_mode  [SLOTS];
    logic [31:0]         n_pos   [SLOTS];
    logic signed [15:0]  n_spd   [SLOTS];
    logic signed [15:0]  n_acc   [SLOTS];
    logic signed [15:0]  n_cur   [SLOTS];
    logic [COUNT_W-1:0]  n_count [SLOTS];

    logic [7:0]          w_slot_id    [SLOT_MAX];
    logic [SLOT_MAX-1:0] w_match;
    logic [SLOT_MAX-1:0] w_tick_active;
    t_mode               w_tick_mode  [SLOT_MAX];
    logic [COUNT_W-1:0]  w_count_inc  [SLOT_MAX];
    t_frame              w_slot_frm   [SLOT_MAX];

    t_kind         w_kind;
    logic          w_accept;
    t_frame        w_f0;
    t_frame        w_f1;
    logic [1:0]    w_n;
    t_frame        w_head;
    t_queue_status w_status;

    // frame for a slot's refresh command
    function automatic t_frame slot_frame(input logic [7:0] id, input t_mode mode,
                                          input logic [31:0] pos,
                                          input logic signed [15:0] spd,
                                          input logic signed [15:0] acc,
                                          input logic signed [15:0] cur);
        t_frame f;
        f = '0;
        unique case (mode)
            MODE_SPEED:   f = make_frame(id, PKT_RPM, BYTES_VALUE, {{16{spd[15]}}, spd}, 32'd0);
            MODE_POS:     f = make_frame(id, PKT_POS, BYTES_VALUE, pos, 32'd0);
            MODE_PSA:     f = make_frame(id, PKT_POS_SPD, BYTES_PSA, pos,
                                         {speed_div10(spd), accel_div10(acc)});
            MODE_CURRENT: f = make_frame(id, PKT_CURRENT, BYTES_VALUE, clamp_current(cur),
                                         32'd0);
            default:      f = '0;
        endcase
        return f;
    endfunction

    assign w_kind    = t_kind'(i_cmd.kind);
    assign w_accept  = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = w_status.room_for_pair;
    assign i_cfg.ready = 1'b1;

    assign w_slot_id[0] = r_first_id;
    assign w_slot_id[1] = r_second_id;

    // per-slot match, tick aging and refresh frame
    for (genvar k = 0; k < SLOT_MAX; k++) begin : g_slot
        if (k < SLOTS) begin : g_used
            if (k == 0) begin : g_first
                assign w_match[k] = (w_slot_id[k] == i_cmd.target_id);
            end else begin : g_other
                assign w_match[k] = (w_slot_id[k] == i_cmd.target_id) && !w_match[0];
            end
            assign w_count_inc[k] = (r_count[k] == COUNT_MAX) ? r_count[k]
                                                              : r_count[k] + COUNT_W'(1);
            assign w_tick_mode[k] = ((r_timeout != 16'd0) &&
                                     (w_count_inc[k] > {1'b0, r_timeout})) ? MODE_IDLE
                                                                           : r_mode[k];
            assign w_tick_active[k] = (w_tick_mode[k] == MODE_SPEED) ||
                                      (w_tick_mode[k] == MODE_POS) ||
                                      (w_tick_mode[k] == MODE_PSA) ||
                                      (w_tick_mode[k] == MODE_CURRENT);
            assign w_slot_frm[k] = slot_frame(w_slot_id[k], r_mode[k], r_pos[k], r_spd[k],
                                              r_acc[k], r_cur[k]);
        end else begin : g_unused
            assign w_match[k]       = 1'b0;
            assign w_count_inc[k]   = '0;
            assign w_tick_mode[k]   = MODE_IDLE;
            assign w_tick_active[k] = 1'b0;
            assign w_slot_frm[k]    = '0;
        end
    end

    // pick the frames this word causes
    always_comb begin
        w_f0 = '0;
        w_f1 = '0;
        w_n  = 2'd0;
        case (w_kind) inside
            KIND_TICK: begin
                if (w_tick_active[0]) begin
                    w_f0 = w_slot_frm[0];
                    w_f1 = w_slot_frm[1];
                    w_n  = 2'd1 + {1'b0, w_tick_active[1]};
                end else begin
                    w_f0 = w_slot_frm[1];
                    w_n  = {1'b0, w_tick_active[1]};
                end
            end
            KIND_SPEED, KIND_POSITION, KIND_POS_SPD_ACC, KIND_CURRENT: begin
                w_n = 2'd0;
            end
            KIND_STOP: begin
                w_f0 = make_frame(i_cmd.target_id, PKT_CURRENT, BYTES_VALUE, 32'd0, 32'd0);
                w_n  = 2'd1;
            end
            KIND_STOP_ALL: begin
                w_f0 = make_frame(w_slot_id[0], PKT_CURRENT, BYTES_VALUE, 32'd0, 32'd0);
                w_f1 = make_frame(w_slot_id[1], PKT_CURRENT, BYTES_VALUE, 32'd0, 32'd0);
                w_n  = 2'(SLOTS);
            end
            KIND_ORIGIN: begin
                w_f0 = make_frame(w_slot_id[0], PKT_ORIGIN, BYTES_ORIGIN,
                                  {i_cmd.home_mode, 24'd0}, 32'd0);
                w_f1 = make_frame(w_slot_id[1], PKT_ORIGIN, BYTES_ORIGIN,
                                  {i_cmd.home_mode, 24'd0}, 32'd0);
                w_n  = 2'(SLOTS);
            end
            default: begin
                w_n = 2'd0;
            end
        endcase
        w_f0.last_frame = (w_n == 2'd1);
        w_f1.last_frame = 1'b1;
    end

    // next slot state
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            n_mode[k]  = r_mode[k];
            n_pos[k]   = r_pos[k];
            n_spd[k]   = r_spd[k];
            n_acc[k]   = r_acc[k];
            n_cur[k]   = r_cur[k];
            n_count[k] = r_count[k];
            if (w_accept) begin
                case (w_kind)
                    KIND_TICK: begin
                        n_count[k] = w_count_inc[k];
                        n_mode[k]  = w_tick_active[k] ? w_tick_mode[k] : MODE_IDLE;
                    end
                    KIND_SPEED: begin
                        if (w_match[k]) begin
                            n_spd[k]   = i_cmd.speed_erpm;
                            n_mode[k]  = MODE_SPEED;
                            n_count[k] = '0;
                        end
                    end
                    KIND_POSITION: begin
                        if (w_match[k]) begin
                            n_pos[k]   = i_cmd.position_e4;
                            n_mode[k]  = MODE_POS;
                            n_count[k] = '0;
                        end
                    end
                    KIND_POS_SPD_ACC: begin
                        if (w_match[k]) begin
                            n_pos[k]   = i_cmd.position_e4;
                            n_spd[k]   = i_cmd.speed_erpm;
                            n_acc[k]   = i_cmd.accel_erpm;
                            n_mode[k]  = MODE_PSA;
                            n_count[k] = '0;
                        end
                    end
                    KIND_CURRENT: begin
                        if (w_match[k]) begin
                            n_cur[k]   = i_cmd.current_ma;
                            n_mode[k]  = MODE_CURRENT;
                            n_count[k] = '0;
                        end
                    end
                    KIND_STOP: begin
                        if (w_match[k]) begin
                            n_mode[k]  = MODE_IDLE;
                            n_count[k] = '0;
                        end
                    end
                    KIND_STOP_ALL: begin
                        n_mode[k]  = MODE_IDLE;
                        n_count[k] = '0;
                    end
                    default: begin
                        n_mode[k] = r_mode[k];
                    end
                endcase
            end
        end
    end

    // hold slot mode and silence count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_mode[k]  <= MODE_IDLE;
                r_count[k] <= '0;
            end
        end else begin
            for (int k = 0; k < SLOTS; k++) begin
                r_mode[k]  <= n_mode[k];
                r_count[k] <= n_count[k];
            end
        end
    end

    // hold setpoints
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_pos[k] <= '0;
                r_spd[k] <= '0;
                r_acc[k] <= '0;
                r_cur[k] <= '0;
            end
        end else begin
            for (int k = 0; k < SLOTS; k++) begin
                r_pos[k] <= n_pos[k];
                r_spd[k] <= n_spd[k];
                r_acc[k] <= n_acc[k];
                r_cur[k] <= n_cur[k];
            end
        end
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_id  <= FIRST_ID_RST;
            r_second_id <= SECOND_ID_RST;
            r_timeout   <= TIMEOUT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_FIRST_ID:  r_first_id  <= i_cfg.data[7:0];
                CFG_SECOND_ID: r_second_id <= i_cfg.data[7:0];
                CFG_TIMEOUT:   r_timeout   <= i_cfg.data;
                default:       r_timeout   <= r_timeout;
            endcase
        end
    end

    mcrs_frame_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_accept ? w_n : 2'd0),
        .i_push0      (w_f0),
        .i_push1      (w_f1),
        .i_pop        (o_frame.valid && o_frame.ready),
        .o_head       (w_head),
        .o_status     (w_status)
    );

    // drive the frame channel from the queue head
    assign o_frame.valid        = (w_status.level != '0);
    assign o_frame.frame_id     = w_head.frame_id;
    assign o_frame.tx_slot      = w_head.tx_slot;
    assign o_frame.byte_count   = w_head.byte_count;
    assign o_frame.payload_high = w_head.payload_high;
    assign o_frame.payload_low  = w_head.payload_low;
    assign o_frame.last_frame   = w_head.last_frame;

    // checks
    `MCRS_ASSERT_IMP(a_pair_stays_together, i_clk, i_rst_n,
                     o_frame.valid && !o_frame.last_frame, w_status.level >= LEVEL_W'(2))
    `MCRS_ASSERT_IMP(a_level_bounded, i_clk, i_rst_n, 1'b1,
                     w_status.level <= LEVEL_W'(QUEUE_DEPTH))
    `MCRS_ASSERT_NXT(a_speed_sets_mode, i_clk, i_rst_n,
                     w_accept && w_kind == KIND_SPEED && i_cmd.target_id == r_first_id,
                     r_mode[0] == MODE_SPEED)
    `MCRS_ASSERT_NXT(a_stop_all_idles, i_clk, i_rst_n, w_accept && w_kind == KIND_STOP_ALL,
                     r_mode[0] == MODE_IDLE && r_count[0] == '0)

endmodule
